### rtl/rau_pkg.sv
// rational arithmetic unit package: widths, operation codes, shared types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = OPERAND_WIDTH;
    localparam int WIDE_W        = 2 * OPERAND_WIDTH;
    localparam int NUM_OUT_W     = 33;
    localparam int DEN_OUT_W     = 31;
    localparam int SHIFT_W       = $clog2(WIDE_W + 1);
    localparam int DIV_CNT_W     = $clog2(WIDE_W + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    typedef logic [1:0]                      mode_t;
    typedef logic signed [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [MAG_W-1:0]                mag_t;
    typedef logic [WIDE_W-1:0]               wide_t;
    typedef logic signed [NUM_OUT_W-1:0]     num_out_t;
    typedef logic [DEN_OUT_W-1:0]            den_out_t;

    localparam mode_t MODE_ADD = 2'd0;
    localparam mode_t MODE_SUB = 2'd1;
    localparam mode_t MODE_MUL = 2'd2;
    localparam mode_t MODE_DIV = 2'd3;

    typedef struct packed {
        mode_t mode;
        logic  sign_na;
        mag_t  mag_na;
        logic  sign_da;
        mag_t  mag_da;
        logic  sign_nb;
        mag_t  mag_nb;
        logic  sign_db;
        mag_t  mag_db;
        logic  bad;
    } job_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

`default_nettype wire

### rtl/rau_if.sv
// operand and result channel interfaces, valid/ready handshake
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rau_op_if;
    import rau_pkg::*;

    logic     valid;
    logic     ready;
    mode_t    mode;
    operand_t num_a;
    operand_t den_a;
    operand_t num_b;
    operand_t den_b;

    modport source (output valid, output mode, output num_a, output den_a,
                    output num_b, output den_b, input ready);
    modport sink   (input valid, input mode, input num_a, input den_a,
                    input num_b, input den_b, output ready);
endinterface

interface rau_res_if;
    import rau_pkg::*;

    logic     valid;
    logic     ready;
    num_out_t num_out;
    den_out_t den_out;
    logic     error;

    modport source (output valid, output num_out, output den_out, output error,
                    input ready);
    modport sink   (input valid, input num_out, input den_out, input error,
                    output ready);
endinterface

`default_nettype wire

### rtl/rau_front.sv
// front end: takes operand beats, splits sign and magnitude, flags bad items
// depends on rau_pkg and rau_op_if
`timescale 1ns / 1ps
`default_nettype none

module rau_front (
    rau_op_if.sink        operand,
    output rau_pkg::job_t job,
    output logic          job_valid,
    input  logic          job_ready
);
    import rau_pkg::*;

    function automatic mag_t magnitude(operand_t v);
        return v[OPERAND_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    assign job_valid     = operand.valid;
    assign operand.ready = job_ready;

    always_comb
    begin
        job.mode    = operand.mode;
        job.sign_na = operand.num_a[OPERAND_WIDTH-1];
        job.mag_na  = magnitude(operand.num_a);
        job.sign_da = operand.den_a[OPERAND_WIDTH-1];
        job.mag_da  = magnitude(operand.den_a);
        job.sign_nb = operand.num_b[OPERAND_WIDTH-1];
        job.mag_nb  = magnitude(operand.num_b);
        job.sign_db = operand.den_b[OPERAND_WIDTH-1];
        job.mag_db  = magnitude(operand.den_b);
        // zero denominator, or divide by a zero fraction
        job.bad     = (job.mag_da == '0) || (job.mag_db == '0) ||
                      ((operand.mode == MODE_DIV) && (job.mag_nb == '0));
    end

endmodule

`default_nettype wire

### rtl/rau_queue.sv
// short job queue between front and back end
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none

module rau_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rau_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rau_pkg::job_t pop_data
);
    import rau_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/rau_div.sv
// restoring divider, one quotient bit per cycle
// depends on rau_pkg
`timescale 1ns / 1ps
`default_nettype none

module rau_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rau_pkg::wide_t    dividend,
    input  rau_pkg::wide_t    divisor,
    output rau_pkg::div_sts_t sts,
    output rau_pkg::wide_t    quotient
);
    import rau_pkg::*;

    wide_t                rem_reg, rem_next;
    wide_t                quo_reg, quo_next;
    wide_t                dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WIDE_W:0]      trial;
    logic [WIDE_W:0]      diff;

    assign trial    = {rem_reg, quo_reg[WIDE_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign sts      = '{busy: busy_reg, done: done_reg};
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        priority if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(WIDE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDE_W])
            begin
                rem_next = diff[WIDE_W-1:0];
                quo_next = {quo_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[WIDE_W-1:0];
                quo_next = {quo_reg[WIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

### rtl/rau_back.sv
// back end sequencer: cross products, sign fold, binary gcd, reduction
// depends on rau_pkg, rau_res_if and rau_div
`timescale 1ns / 1ps
`default_nettype none

module rau_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  rau_pkg::job_t job,
    rau_res_if.source     result
);
    import rau_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_MUL1    = 4'd1;
    localparam logic [3:0] ST_MUL2    = 4'd2;
    localparam logic [3:0] ST_MUL3    = 4'd3;
    localparam logic [3:0] ST_COMB    = 4'd4;
    localparam logic [3:0] ST_GCD_SH  = 4'd5;
    localparam logic [3:0] ST_GCD_A   = 4'd6;
    localparam logic [3:0] ST_GCD_B   = 4'd7;
    localparam logic [3:0] ST_DN_GO   = 4'd8;
    localparam logic [3:0] ST_DN_WAIT = 4'd9;
    localparam logic [3:0] ST_DD_GO   = 4'd10;
    localparam logic [3:0] ST_DD_WAIT = 4'd11;
    localparam logic [3:0] ST_OUT     = 4'd12;

    logic [3:0]         state_reg, state_next;
    job_t               job_reg, job_next;
    wide_t              m1_reg, m1_next;
    wide_t              m2_reg, m2_next;
    wide_t              m3_reg, m3_next;
    wide_t              rn_reg, rn_next;
    wide_t              rd_reg, rd_next;
    wide_t              ga_reg, ga_next;
    wide_t              gb_reg, gb_next;
    wide_t              g_reg, g_next;
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               neg_reg, neg_next;
    logic               err_reg, err_next;

    mag_t               mul_x, mul_y;
    wide_t              mul_p;
    logic               add_sub;
    logic               s1, s2, rn_neg, rd_neg;
    wide_t              rn_c, rd_c;
    logic               div_start;
    wide_t              div_dividend;
    wide_t              div_quotient;
    div_sts_t           div_sts;
    num_out_t           num_mag;

    assign add_sub = (job_reg.mode == MODE_ADD) || (job_reg.mode == MODE_SUB);

    always_comb
    begin
        mul_x = job_reg.mag_da;
        mul_y = job_reg.mag_db;
        unique case (state_reg)
            ST_MUL1:
            begin
                mul_x = job_reg.mag_na;
                mul_y = (job_reg.mode == MODE_MUL) ? job_reg.mag_nb : job_reg.mag_db;
            end
            ST_MUL2:
            begin
                mul_x = job_reg.mag_da;
                mul_y = (job_reg.mode == MODE_MUL) ? job_reg.mag_db : job_reg.mag_nb;
            end
            default:
            begin
                mul_x = job_reg.mag_da;
                mul_y = job_reg.mag_db;
            end
        endcase
    end

    assign mul_p = wide_t'(mul_x) * wide_t'(mul_y);

    // sign and magnitude of the combined numerator and denominator
    always_comb
    begin
        s1     = job_reg.sign_na ^ job_reg.sign_db;
        s2     = job_reg.sign_nb ^ job_reg.sign_da ^ (job_reg.mode == MODE_SUB);
        rn_c   = m1_reg;
        rn_neg = s1;
        rd_c   = m2_reg;
        rd_neg = job_reg.sign_da ^ job_reg.sign_nb;
        if (add_sub)
        begin
            rd_c   = m3_reg;
            rd_neg = job_reg.sign_da ^ job_reg.sign_db;
            priority if (s1 == s2)
            begin
                rn_c = m1_reg + m2_reg;
            end
            else if (m1_reg >= m2_reg)
            begin
                rn_c = m1_reg - m2_reg;
            end
            else
            begin
                rn_c   = m2_reg - m1_reg;
                rn_neg = s2;
            end
        end
        else if (job_reg.mode == MODE_MUL)
        begin
            rn_neg = job_reg.sign_na ^ job_reg.sign_nb;
            rd_neg = job_reg.sign_da ^ job_reg.sign_db;
        end
    end

    assign div_start    = (state_reg == ST_DN_GO) || (state_reg == ST_DD_GO);
    assign div_dividend = (state_reg == ST_DN_GO) ? rn_reg : rd_reg;

    rau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (g_reg),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        m1_next    = m1_reg;
        m2_next    = m2_reg;
        m3_next    = m3_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        g_next     = g_reg;
        shift_next = shift_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_next = job;
                    err_next = job.bad;
                    if (job.bad)
                    begin
                        rn_next    = '0;
                        rd_next    = wide_t'(1);
                        neg_next   = 1'b0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                m1_next    = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                m2_next    = mul_p;
                state_next = add_sub ? ST_MUL3 : ST_COMB;
            end
            ST_MUL3:
            begin
                m3_next    = mul_p;
                state_next = ST_COMB;
            end
            ST_COMB:
            begin
                if (rn_c == '0)
                begin
                    rn_next    = '0;
                    rd_next    = wide_t'(1);
                    neg_next   = 1'b0;
                    state_next = ST_OUT;
                end
                else
                begin
                    rn_next    = rn_c;
                    rd_next    = rd_c;
                    neg_next   = rn_neg ^ rd_neg;
                    ga_next    = rn_c;
                    gb_next    = rd_c;
                    shift_next = '0;
                    state_next = ST_GCD_SH;
                end
            end
            ST_GCD_SH:
            begin
                if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next    = ga_reg >> 1;
                    gb_next    = gb_reg >> 1;
                    shift_next = shift_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_GCD_A;
                end
            end
            ST_GCD_A:
            begin
                if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else
                begin
                    state_next = ST_GCD_B;
                end
            end
            ST_GCD_B:
            begin
                priority if (gb_reg == '0)
                begin
                    g_next     = ga_reg << shift_reg;
                    state_next = ST_DN_GO;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_reg > gb_reg)
                begin
                    ga_next = gb_reg;
                    gb_next = ga_reg - gb_reg;
                end
                else
                begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            ST_DN_GO:
            begin
                state_next = ST_DN_WAIT;
            end
            ST_DN_WAIT:
            begin
                if (div_sts.done)
                begin
                    rn_next    = div_quotient;
                    state_next = ST_DD_GO;
                end
            end
            ST_DD_GO:
            begin
                state_next = ST_DD_WAIT;
            end
            ST_DD_WAIT:
            begin
                if (div_sts.done)
                begin
                    rd_next    = div_quotient;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        m3_reg    <= m3_next;
        rn_reg    <= rn_next;
        rd_reg    <= rd_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        g_reg     <= g_next;
        shift_reg <= shift_next;
        neg_reg   <= neg_next;
        err_reg   <= err_next;
    end

    assign job_ready      = (state_reg == ST_IDLE);
    assign num_mag        = NUM_OUT_W'(rn_reg);
    assign result.valid   = (state_reg == ST_OUT);
    assign result.num_out = neg_reg ? -num_mag : num_mag;
    assign result.den_out = DEN_OUT_W'(rd_reg);
    assign result.error   = err_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.error) |-> (result.num_out == '0) && (result.den_out == 1))
        else $error("error beat without 0/1 result");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.error) |-> (result.den_out != '0))
        else $error("zero denominator on result beat");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divider started while busy");

    a_gcd_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD_B) |-> ga_reg[0])
        else $error("gcd loop entered with even operand");
`endif

endmodule

`default_nettype wire

### rtl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit: add, subtract, multiply or divide two signed
// fractions and return the result in lowest terms with a positive denominator.
// An item in the back end passes through these steps: it takes the job, forms
// three products (add, subtract) or two (multiply, divide) on the shared 16x16
// multiplier, folds the signs, runs a binary gcd loop of one shift or subtract
// per cycle, divides by the gcd twice (start, 32 quotient bits, done) and then
// gives the result beat. Items with a zero denominator, a divide by zero or a
// zero result skip the gcd loop and the divisions. A two-entry queue lets the
// operand side keep taking beats while the back end works and a result beat
// waits.
// depends on rau_pkg, rau_if, rau_front, rau_queue, rau_back
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit_core (
    input  logic  clk,
    input  logic  rst_n,
    rau_op_if.sink    operand,
    rau_res_if.source result
);
    import rau_pkg::*;

    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t back_job;
    logic back_valid;
    logic back_ready;

    rau_front u_front (
        .operand   (operand),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    rau_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .result    (result)
    );

endmodule

`default_nettype wire
